>>> src/abr_pkg.sv
// Shared constants, codes and types for the anchor bounding-box refine block.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package abr_pkg;

  // Field widths fixed by the channel format.
  localparam int AXIS_BITS      = 20;
  localparam int OP_BITS        = 2;
  localparam int RANGE_BITS     = 16;
  localparam int REG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 20;

  // Default width of the stored box bounds.
  localparam int COORD_BITS_DEFAULT = 20;

  // Operation codes.
  localparam logic [OP_BITS-1:0] OP_ONE_HOP = 2'd0;
  localparam logic [OP_BITS-1:0] OP_TWO_HOP = 2'd1;
  localparam logic [OP_BITS-1:0] OP_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_INDEX_BITS-1:0] REG_RADIO_RANGE  = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_IDEAL_RANGE  = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_FIELD_WIDTH  = 2'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_FIELD_HEIGHT = 2'd3;

  // Register values after reset.
  localparam logic [RANGE_BITS-1:0] RADIO_RANGE_RST  = 16'd1600;
  localparam logic [RANGE_BITS-1:0] IDEAL_RANGE_RST  = 16'd1280;
  localparam logic [AXIS_BITS-1:0]  FIELD_WIDTH_RST  = 20'd16000;
  localparam logic [AXIS_BITS-1:0]  FIELD_HEIGHT_RST = 20'd16000;

  typedef struct packed {
    logic [RANGE_BITS-1:0] radio_reach;
    logic [RANGE_BITS-1:0] ideal_reach;
    logic [AXIS_BITS-1:0]  field_width;
    logic [AXIS_BITS-1:0]  field_height;
  } abr_cfg_t;

endpackage

`default_nettype wire

>>> src/abr_in_if.sv
// Input channel of the anchor bounding-box refine block: one anchor word.
// Depends on abr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface abr_in_if;
  logic                          valid;
  logic                          ready;
  logic [abr_pkg::OP_BITS-1:0]   op;
  logic [abr_pkg::AXIS_BITS-1:0] anchor_x;
  logic [abr_pkg::AXIS_BITS-1:0] anchor_y;

  modport source (output valid, op, anchor_x, anchor_y, input ready);
  modport sink   (input valid, op, anchor_x, anchor_y, output ready);
endinterface

`default_nettype wire

>>> src/abr_out_if.sv
// Result channel of the anchor bounding-box refine block: one box word.
// Depends on abr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface abr_out_if;
  logic                          valid;
  logic                          ready;
  logic [abr_pkg::AXIS_BITS-1:0] box_xmin;
  logic [abr_pkg::AXIS_BITS-1:0] box_ymin;
  logic [abr_pkg::AXIS_BITS-1:0] box_xmax;
  logic [abr_pkg::AXIS_BITS-1:0] box_ymax;
  logic                          accepted;
  logic                          history_cleared;

  modport source (output valid, box_xmin, box_ymin, box_xmax, box_ymax, accepted,
                  history_cleared, input ready);
  modport sink   (input valid, box_xmin, box_ymin, box_xmax, box_ymax, accepted,
                  history_cleared, output ready);
endinterface

`default_nettype wire

>>> src/abr_cfg_if.sv
// Configuration write channel of the anchor bounding-box refine block.
// Depends on abr_pkg for the index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface abr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [abr_pkg::REG_INDEX_BITS-1:0] index;
  logic [abr_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/abr_cfg_regs.sv
// Configuration register file: radio range, ideal range and field extents.
// Depends on abr_pkg and abr_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module abr_cfg_regs (
  input  wire logic       clk,
  input  wire logic       rst_n,
  abr_cfg_if.sink         cfg_ch,
  output abr_pkg::abr_cfg_t cfg
);

  abr_pkg::abr_cfg_t cfg_r;
  logic              wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radio_reach  <= abr_pkg::RADIO_RANGE_RST;
      cfg_r.ideal_reach  <= abr_pkg::IDEAL_RANGE_RST;
      cfg_r.field_width  <= abr_pkg::FIELD_WIDTH_RST;
      cfg_r.field_height <= abr_pkg::FIELD_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (cfg_ch.index)
        abr_pkg::REG_RADIO_RANGE:  cfg_r.radio_reach  <= cfg_ch.data[abr_pkg::RANGE_BITS-1:0];
        abr_pkg::REG_IDEAL_RANGE:  cfg_r.ideal_reach  <= cfg_ch.data[abr_pkg::RANGE_BITS-1:0];
        abr_pkg::REG_FIELD_WIDTH:  cfg_r.field_width  <= cfg_ch.data[abr_pkg::AXIS_BITS-1:0];
        abr_pkg::REG_FIELD_HEIGHT: cfg_r.field_height <= cfg_ch.data[abr_pkg::AXIS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/abr_refine.sv
// Combinational box refinement: anchor box, overlap and two-hop tests, new box.
// Depends on abr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abr_refine #(
  parameter int COORD_BITS = abr_pkg::COORD_BITS_DEFAULT
) (
  input  wire abr_pkg::abr_cfg_t               cfg,
  input  wire logic [abr_pkg::OP_BITS-1:0]     op,
  input  wire logic [abr_pkg::AXIS_BITS-1:0]   anchor_x,
  input  wire logic [abr_pkg::AXIS_BITS-1:0]   anchor_y,
  input  wire logic [COORD_BITS-1:0]           kept_xmin,
  input  wire logic [COORD_BITS-1:0]           kept_ymin,
  input  wire logic [COORD_BITS-1:0]           kept_xmax,
  input  wire logic [COORD_BITS-1:0]           kept_ymax,
  output logic      [COORD_BITS-1:0]           new_xmin,
  output logic      [COORD_BITS-1:0]           new_ymin,
  output logic      [COORD_BITS-1:0]           new_xmax,
  output logic      [COORD_BITS-1:0]           new_ymax,
  output logic                                 accepted,
  output logic                                 history_cleared
);

  // Signed working width: wide enough for an anchor box that reaches below
  // zero or above the largest coordinate, plus the ideal-range margin.
  localparam int AXB = abr_pkg::AXIS_BITS;
  localparam int SW  = ((COORD_BITS > AXB) ? COORD_BITS : AXB) + 2;
  localparam int RB  = abr_pkg::RANGE_BITS;

  typedef logic signed [SW-1:0] sval_t;

  logic [RB:0]             span;
  logic [COORD_BITS-1:0]   fw_masked;
  logic [COORD_BITS-1:0]   fh_masked;
  sval_t ax_s, ay_s, span_s, d_s, fw_s, fh_s;
  sval_t a_x0, a_y0, a_x1, a_y1;
  sval_t k_x0, k_y0, k_x1, k_y1;
  sval_t n_x0, n_y0, n_x1, n_y1;
  logic  overlap;
  logic  contained;

  // A two-hop anchor doubles the radio range.
  assign span   = (op == abr_pkg::OP_TWO_HOP) ? {cfg.radio_reach, 1'b0}
                                              : {1'b0, cfg.radio_reach};
  assign span_s = $signed(SW'(span));
  assign d_s    = $signed(SW'(cfg.ideal_reach));

  assign fw_masked = COORD_BITS'(cfg.field_width);
  assign fh_masked = COORD_BITS'(cfg.field_height);
  assign fw_s      = $signed(SW'(fw_masked));
  assign fh_s      = $signed(SW'(fh_masked));

  assign ax_s = $signed(SW'(anchor_x));
  assign ay_s = $signed(SW'(anchor_y));
  assign a_x0 = ax_s - span_s;
  assign a_y0 = ay_s - span_s;
  assign a_x1 = ax_s + span_s;
  assign a_y1 = ay_s + span_s;

  assign k_x0 = $signed(SW'(kept_xmin));
  assign k_y0 = $signed(SW'(kept_ymin));
  assign k_x1 = $signed(SW'(kept_xmax));
  assign k_y1 = $signed(SW'(kept_ymax));

  // Closed-interval overlap on both axes; touching edges count.
  assign overlap = (a_x0 <= k_x1) && (a_x1 >= k_x0) && (a_y0 <= k_y1) && (a_y1 >= k_y0);

  // Kept box lies within the anchor box shrunk by the ideal range.
  assign contained = (k_x0 >= a_x0 + d_s) && (k_y0 >= a_y0 + d_s) &&
                     (k_x1 <= a_x1 - d_s) && (k_y1 <= a_y1 - d_s);

  always_comb begin
    n_x0            = k_x0;
    n_y0            = k_y0;
    n_x1            = k_x1;
    n_y1            = k_y1;
    accepted        = 1'b0;
    history_cleared = 1'b0;
    unique case (op) inside
      abr_pkg::OP_RESTART: begin
        n_x0            = '0;
        n_y0            = '0;
        n_x1            = fw_s;
        n_y1            = fh_s;
        history_cleared = 1'b1;
      end
      abr_pkg::OP_ONE_HOP, abr_pkg::OP_TWO_HOP: begin
        if (overlap) begin
          if (!((op == abr_pkg::OP_TWO_HOP) && contained)) begin
            n_x0     = (a_x0 > k_x0) ? a_x0 : k_x0;
            n_y0     = (a_y0 > k_y0) ? a_y0 : k_y0;
            n_x1     = (a_x1 < k_x1) ? a_x1 : k_x1;
            n_y1     = (a_y1 < k_y1) ? a_y1 : k_y1;
            accepted = 1'b1;
          end
        end else begin
          // Disjoint: restart from the anchor box clamped to the field.
          n_x0            = (a_x0 > sval_t'(0)) ? a_x0 : sval_t'(0);
          n_y0            = (a_y0 > sval_t'(0)) ? a_y0 : sval_t'(0);
          n_x1            = (a_x1 < fw_s) ? a_x1 : fw_s;
          n_y1            = (a_y1 < fh_s) ? a_y1 : fh_s;
          accepted        = 1'b1;
          history_cleared = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign new_xmin = COORD_BITS'(n_x0);
  assign new_ymin = COORD_BITS'(n_y0);
  assign new_xmax = COORD_BITS'(n_x1);
  assign new_ymax = COORD_BITS'(n_y1);

endmodule

`default_nettype wire

>>> src/anchor_bounding_box_refine.sv
// Top level of the anchor bounding-box refine block: input register, kept box,
// result register. Depends on abr_pkg, the channel interfaces, abr_cfg_regs, abr_refine.
//
//   in_ch carries one anchor word per handshake: an op code (one-hop anchor,
//   two-hop anchor or restart) and the anchor position. out_ch returns one
//   result word for every input word: the kept box after the step, whether
//   the anchor was used, and whether the anchor history was cleared.
//   cfg_ch writes the radio range, ideal range and field extents; it is
//   always ready and should only be written while no word is in flight.
//   An accepted word goes into the input register and then into the result
//   register, which drives out_ch.valid; a stalled receiver can hold it back.
//   Throughput is one word per cycle unless the receiver stalls: the kept box
//   is updated in the same cycle a word moves from the input register to the
//   result register, so the next word always sees the box the last one left.
//   When the receiver stalls, the result register holds its word and the
//   input register takes one more word; in_ch.ready drops only when both
//   are full, and rises again in the cycle the receiver takes its word.
//   Reset (synchronous, active low) empties both registers, restores the
//   configuration defaults and sets the kept box to the full default field.
`timescale 1ns / 1ps
`default_nettype none

module anchor_bounding_box_refine #(
  parameter int COORD_BITS = abr_pkg::COORD_BITS_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst_n,
  abr_in_if.sink    in_ch,
  abr_out_if.source out_ch,
  abr_cfg_if.sink   cfg_ch
);

  localparam int AXB = abr_pkg::AXIS_BITS;

  abr_pkg::abr_cfg_t cfg;

  // Input register stage.
  logic                          s1_valid_r;
  logic [abr_pkg::OP_BITS-1:0]   s1_op_r;
  logic [AXB-1:0]                s1_ax_r;
  logic [AXB-1:0]                s1_ay_r;

  // Kept box.
  logic [COORD_BITS-1:0] box_xmin_r, box_ymin_r, box_xmax_r, box_ymax_r;
  logic [COORD_BITS-1:0] box_xmin_nxt, box_ymin_nxt, box_xmax_nxt, box_ymax_nxt;
  logic                  accepted_nxt, cleared_nxt;

  // Result register stage.
  logic           out_valid_r;
  logic [AXB-1:0] out_xmin_r, out_ymin_r, out_xmax_r, out_ymax_r;
  logic           out_acc_r, out_clr_r;

  logic out_free;
  logic s1_move;
  logic in_take;

  abr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  abr_refine #(.COORD_BITS(COORD_BITS)) u_refine (
    .cfg             (cfg),
    .op              (s1_op_r),
    .anchor_x        (s1_ax_r),
    .anchor_y        (s1_ay_r),
    .kept_xmin       (box_xmin_r),
    .kept_ymin       (box_ymin_r),
    .kept_xmax       (box_xmax_r),
    .kept_ymax       (box_ymax_r),
    .new_xmin        (box_xmin_nxt),
    .new_ymin        (box_ymin_nxt),
    .new_xmax        (box_xmax_nxt),
    .new_ymax        (box_ymax_nxt),
    .accepted        (accepted_nxt),
    .history_cleared (cleared_nxt)
  );

  // The result register can take a word when it is empty or being drained.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r <= in_ch.op;
      s1_ax_r <= in_ch.anchor_x;
      s1_ay_r <= in_ch.anchor_y;
    end
  end

  // The box only changes when a word leaves the input register, so words
  // are applied strictly in arrival order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_xmin_r <= '0;
      box_ymin_r <= '0;
      box_xmax_r <= COORD_BITS'(abr_pkg::FIELD_WIDTH_RST);
      box_ymax_r <= COORD_BITS'(abr_pkg::FIELD_HEIGHT_RST);
    end else if (s1_move) begin
      box_xmin_r <= box_xmin_nxt;
      box_ymin_r <= box_ymin_nxt;
      box_xmax_r <= box_xmax_nxt;
      box_ymax_r <= box_ymax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_xmin_r <= AXB'(box_xmin_nxt);
      out_ymin_r <= AXB'(box_ymin_nxt);
      out_xmax_r <= AXB'(box_xmax_nxt);
      out_ymax_r <= AXB'(box_ymax_nxt);
      out_acc_r  <= accepted_nxt;
      out_clr_r  <= cleared_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.box_xmin        = out_xmin_r;
  assign out_ch.box_ymin        = out_ymin_r;
  assign out_ch.box_xmax        = out_xmax_r;
  assign out_ch.box_ymax        = out_ymax_r;
  assign out_ch.accepted        = out_acc_r;
  assign out_ch.history_cleared = out_clr_r;

endmodule

`default_nettype wire
